@@ hw/rtl/civil_datetime_to_epoch_seconds_assert.svh @@
// Assertion macros used by the checker file.
`ifndef CIVIL_DATETIME_TO_EPOCH_SECONDS_ASSERT_SVH
`define CIVIL_DATETIME_TO_EPOCH_SECONDS_ASSERT_SVH

// Clocked assertion, quiet while reset is held.
`define CDTE_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Clocked assertion that also covers the reset cycles.
`define CDTE_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ hw/rtl/cdte_pkg.sv @@
package cdte_pkg;

    localparam int S_TDATA_W = 48;
    localparam int M_TDATA_W = 48;

    // Configuration register indexes
    localparam logic [1:0] CFG_MINUTE_ENABLED = 2'd0;
    localparam logic [1:0] CFG_SECOND_ENABLED = 2'd1;
    localparam logic [1:0] CFG_HOURS_FROM_UTC = 2'd2;

    // Day count bias: shifted year (year + 400) back to 1970-01-01
    localparam int unsigned DAY_BIAS = 865565;

    // floor(q / 25) == (q * RECIP25) >> RECIP25_SHIFT for q < 4699
    localparam logic [10:0] RECIP25       = 11'd1311;
    localparam int          RECIP25_SHIFT = 15;

    localparam logic signed [38:0] OUT_MAX = {1'b0, {38{1'b1}}};
    localparam logic signed [38:0] OUT_MIN = {1'b1, {38{1'b0}}};

    typedef struct packed {
        logic       minute_enabled;
        logic       second_enabled;
        logic signed [5:0] hours_from_utc;
    } cdte_cfg_t;

    typedef struct packed {
        logic [13:0] year;
        logic        year_valid;
        logic [3:0]  month;
        logic        month_valid;
        logic [4:0]  day;
        logic        day_valid;
        logic [4:0]  hour;
        logic        hour_valid;
        logic [5:0]  minute;
        logic [5:0]  second;
    } cdte_item_t;

    typedef struct packed {
        logic              before_epoch;
        logic              is_missing;
        logic signed [38:0] offset_seconds;
    } cdte_result_t;

    // Day of a March-based year on which the given month starts.
    function automatic logic [8:0] month_start_doy(input logic [3:0] month);
        logic [8:0] doy;
        unique case (month)
            4'd3:    doy = 9'd0;
            4'd4:    doy = 9'd31;
            4'd5:    doy = 9'd61;
            4'd6:    doy = 9'd92;
            4'd7:    doy = 9'd122;
            4'd8:    doy = 9'd153;
            4'd9:    doy = 9'd184;
            4'd10:   doy = 9'd214;
            4'd11:   doy = 9'd245;
            4'd12:   doy = 9'd275;
            4'd1:    doy = 9'd306;
            4'd2:    doy = 9'd337;
            default: doy = 9'd0;
        endcase
        return doy;
    endfunction

endpackage

@@ hw/rtl/cdte_core.sv @@
module cdte_core import cdte_pkg::*; (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         ce,
    input  logic         in_valid,
    input  cdte_item_t   in_item,
    input  cdte_cfg_t    cfg,
    output logic         res_valid,
    output cdte_result_t res
);

    // Stage 1: field decode, leap-year counts, time of day
    logic        s1_valid_reg;
    logic        s1_missing_reg;
    logic [14:0] s1_yp_reg;
    logic [7:0]  s1_c100_reg;
    logic [8:0]  s1_doy_reg;
    logic [4:0]  s1_day_reg;
    logic [16:0] s1_tod_reg;

    logic        s1_missing_next;
    logic [14:0] s1_yp_next;
    logic [23:0] c100_prod;
    logic [5:0]  min_eff;
    logic [5:0]  sec_eff;
    logic [16:0] s1_tod_next;

    always_comb begin
        s1_missing_next = !in_item.year_valid || !in_item.month_valid ||
                          !in_item.day_valid || !in_item.hour_valid ||
                          (in_item.month == 4'd0) || (in_item.month > 4'd12);
        // January and February count with the previous year
        s1_yp_next = 15'(in_item.year) + 15'd400 - 15'(in_item.month <= 4'd2);
        c100_prod  = 24'(s1_yp_next[14:2]) * 24'(RECIP25);
        min_eff    = (cfg.minute_enabled && in_item.minute <= 6'd59) ? in_item.minute : 6'd0;
        sec_eff    = (cfg.second_enabled && in_item.second <= 6'd59) ? in_item.second : 6'd0;
        s1_tod_next = 17'(in_item.hour) * 17'd3600 + 17'(min_eff) * 17'd60 + 17'(sec_eff);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (ce) begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            s1_missing_reg <= s1_missing_next;
            s1_yp_reg      <= s1_yp_next;
            s1_c100_reg    <= c100_prod[RECIP25_SHIFT +: 8];
            s1_doy_reg     <= month_start_doy(in_item.month);
            s1_day_reg     <= in_item.day;
            s1_tod_reg     <= s1_tod_next;
        end
    end

    // Stage 2: day count since epoch
    logic               s2_valid_reg;
    logic               s2_missing_reg;
    logic signed [23:0] s2_days_reg;
    logic [16:0]        s2_tod_reg;

    logic [23:0] yp365;
    logic [24:0] days_sum;

    always_comb begin
        yp365    = 24'(s1_yp_reg) * 24'd365;
        days_sum = 25'(yp365) + 25'(s1_yp_reg[14:2]) - 25'(s1_c100_reg)
                 + 25'(s1_c100_reg[7:2]) + 25'(s1_doy_reg) + 25'(s1_day_reg)
                 - 25'd1 - 25'(DAY_BIAS);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s2_valid_reg <= 1'b0;
        end else if (ce) begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            s2_missing_reg <= s1_missing_reg;
            s2_days_reg    <= $signed(days_sum[23:0]);
            s2_tod_reg     <= s1_tod_reg;
        end
    end

    // Stage 3: seconds since epoch before the hour offset
    logic               s3_valid_reg;
    logic               s3_missing_reg;
    logic signed [40:0] s3_base_reg;

    logic signed [40:0] base_next;

    always_comb begin
        base_next = 41'(s2_days_reg) * 41'sd86400 + $signed({24'd0, s2_tod_reg});
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s3_valid_reg <= 1'b0;
        end else if (ce) begin
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            s3_missing_reg <= s2_missing_reg;
            s3_base_reg    <= base_next;
        end
    end

    // Offset, clamp to 39 bits, missing override
    logic signed [17:0] off_sec;
    logic signed [41:0] res_wide;

    always_comb begin
        off_sec  = 18'(cfg.hours_from_utc) * 18'sd3600;
        res_wide = 42'(s3_base_reg) + 42'(off_sec);
        res      = '0;
        if (!s3_missing_reg) begin
            res.before_epoch = s3_base_reg[40];
            priority if (res_wide > 42'(OUT_MAX)) begin
                res.offset_seconds = OUT_MAX;
            end else if (res_wide < 42'(OUT_MIN)) begin
                res.offset_seconds = OUT_MIN;
            end else begin
                res.offset_seconds = res_wide[38:0];
            end
        end else begin
            res.is_missing = 1'b1;
        end
    end

    assign res_valid = s3_valid_reg;

endmodule

@@ hw/rtl/civil_datetime_to_epoch_seconds.sv @@
// An s_ transaction accepted at an edge loads s1, then passes through s2, s3 and
// the output register, whose valid drives m_tvalid.
// Throughput: one transaction per cycle while the skid entry is free.
// The output register plus a one-entry skid buffer keep s_tready registered;
// s_tready drops only while the skid entry is occupied.
// Reset (aresetn low, synchronous) empties the pipeline and sets
// minute_enabled = 1, second_enabled = 0, hours_from_utc = 0.
module civil_datetime_to_epoch_seconds import cdte_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_we,
    input  logic [1:0]           cfg_index,
    input  logic [5:0]           cfg_wdata,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // year[13:0], year_valid[14], month[18:15], month_valid[19], day[24:20],
    // day_valid[25], hour[30:26], hour_valid[31], minute[37:32], second[43:38]
    input  logic [S_TDATA_W-1:0] s_tdata,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // offset_seconds[38:0], is_missing[39], before_epoch[40]
    output logic [M_TDATA_W-1:0] m_tdata
);

    cdte_cfg_t cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.minute_enabled <= 1'b1;
            cfg_reg.second_enabled <= 1'b0;
            cfg_reg.hours_from_utc <= 6'sd0;
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_MINUTE_ENABLED: cfg_reg.minute_enabled <= cfg_wdata[0];
                CFG_SECOND_ENABLED: cfg_reg.second_enabled <= cfg_wdata[0];
                CFG_HOURS_FROM_UTC: cfg_reg.hours_from_utc <= $signed(cfg_wdata);
                default: ;
            endcase
        end
    end

    cdte_item_t in_item;

    always_comb begin
        in_item.year        = s_tdata[13:0];
        in_item.year_valid  = s_tdata[14];
        in_item.month       = s_tdata[18:15];
        in_item.month_valid = s_tdata[19];
        in_item.day         = s_tdata[24:20];
        in_item.day_valid   = s_tdata[25];
        in_item.hour        = s_tdata[30:26];
        in_item.hour_valid  = s_tdata[31];
        in_item.minute      = s_tdata[37:32];
        in_item.second      = s_tdata[43:38];
    end

    logic         skid_valid_reg;
    logic         skid_valid_next;
    cdte_result_t skid_reg;
    cdte_result_t skid_next;
    logic         out_valid_reg;
    logic         out_valid_next;
    cdte_result_t out_reg;
    cdte_result_t out_next;

    logic         ce;
    logic         res_valid;
    cdte_result_t res;

    // Whole pipeline advances while the skid entry is free
    assign ce       = !skid_valid_reg;
    assign s_tready = ce;

    cdte_core u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ce        (ce),
        .in_valid  (s_tvalid),
        .in_item   (in_item),
        .cfg       (cfg_reg),
        .res_valid (res_valid),
        .res       (res)
    );

    logic take;
    logic push;

    always_comb begin
        take            = out_valid_reg && m_tready;
        push            = ce && res_valid;
        out_valid_next  = out_valid_reg;
        out_next        = out_reg;
        skid_valid_next = skid_valid_reg;
        skid_next       = skid_reg;
        priority if (skid_valid_reg) begin
            if (take) begin
                out_next        = skid_reg;
                skid_valid_next = 1'b0;
            end
        end else if (push) begin
            if (!out_valid_reg || take) begin
                out_next       = res;
                out_valid_next = 1'b1;
            end else begin
                skid_next       = res;
                skid_valid_next = 1'b1;
            end
        end else if (take) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'd0, out_reg.before_epoch, out_reg.is_missing,
                       out_reg.offset_seconds};

endmodule

@@ hw/rtl/cdte_checker.sv @@
`include "civil_datetime_to_epoch_seconds_assert.svh"

module cdte_checker import cdte_pkg::*; (
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_tready,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata
);

    `CDTE_ASSERT(a_m_valid_holds, aclk, aresetn, m_tvalid && !m_tready |=> m_tvalid, "m_tvalid dropped while stalled")

    `CDTE_ASSERT(a_m_data_holds, aclk, aresetn, m_tvalid && !m_tready |=> $stable(m_tdata), "m_tdata changed while stalled")

    `CDTE_ASSERT(a_missing_zero, aclk, aresetn, m_tvalid && m_tdata[39] |-> (m_tdata[38:0] == 39'd0) && !m_tdata[40], "missing result carries nonzero fields")

    `CDTE_ASSERT_ALWAYS(a_reset_empty, aclk, !aresetn |=> !m_tvalid && s_tready, "pipeline not empty after reset")

endmodule

bind civil_datetime_to_epoch_seconds cdte_checker u_cdte_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
